// ===== rtl/bmu_pkg.sv =====
`timescale 1ns / 1ps

package bmu_pkg;

  localparam int CB          = 8;
  localparam int CODE_MAX    = 2 ** CB - 1;
  localparam int NUM_W       = 4 * CB + 4;
  localparam int DEN_W       = CB + 17;
  localparam int OP_W        = CB + 16;
  localparam int K_W         = CB + 2;
  localparam int SQ_W        = 17;
  localparam int DIV_STAGES  = (CB + 1) / 2;
  localparam int FRONT_STAGES = 2;
  localparam int LATENCY     = FRONT_STAGES + 1 + DIV_STAGES;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(1);
  localparam logic [8:0] ALPHA_RESET = 9'd154;

  typedef enum logic [3:0] {
    MODE_TRANSP    = 4'd0,
    MODE_DARKEN    = 4'd1,
    MODE_LIGHTEN   = 4'd2,
    MODE_MULTIPLY  = 4'd3,
    MODE_SCREEN    = 4'd4,
    MODE_ADD       = 4'd5,
    MODE_LINBURN   = 4'd6,
    MODE_DODGE     = 4'd7,
    MODE_BURN      = 4'd8,
    MODE_OVERLAY   = 4'd9,
    MODE_HARDLIGHT = 4'd10,
    MODE_SOFTLIGHT = 4'd11,
    MODE_DIFF      = 4'd12
  } mode_e;

  typedef struct packed {
    logic [CB-1:0] a_blue;
    logic [CB-1:0] a_green;
    logic [CB-1:0] a_red;
    logic [CB-1:0] b_blue;
    logic [CB-1:0] b_green;
    logic [CB-1:0] b_red;
  } pix_in_t;

  typedef struct packed {
    logic [CB-1:0] out_blue;
    logic [CB-1:0] out_green;
    logic [CB-1:0] out_red;
  } pix_out_t;

  typedef logic [SQ_W-1:0] sqrt_tbl_t [2 ** CB];

  // floor(2^16 * sqrt(b / max)) for every code b, built at elaboration
  function automatic sqrt_tbl_t build_sqrt();
    sqrt_tbl_t t;
    longint unsigned x;
    longint unsigned r;
    longint unsigned bt;
    for (int b = 0; b < 2 ** CB; b++) begin
      x  = (longint'(b) << 32) / CODE_MAX;
      r  = 0;
      bt = 64'h1 << 62;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
        if (x >= r + bt) begin
          x = x - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      t[b] = SQ_W'(r);
    end
    return t;
  endfunction

  localparam sqrt_tbl_t SQRT_TBL = build_sqrt();

endpackage

// ===== rtl/pixel_blend_mode_unit_top.sv =====
`timescale 1ns / 1ps

// Layer blend unit: blends one RGB pixel pair per transfer.
// Input channel: in_valid_i / in_ready_o with in_data_i holding the three
// channels of layer A and layer B. Output channel: out_valid_o /
// out_ready_i with out_data_o holding the three blended channels.
// Configuration channel: cfg_valid_i / cfg_ready_o, index 0 selects the
// blend mode, index 1 the layer B weight for transparency; other indices
// are dropped. Write configuration only while the pipeline is empty.
// Throughput: one pixel per clock unless the receiver stalls. Each pixel passes
// two product stages, a set-up stage and four divider stages of two quotient
// bits each in the restoring divider before its result is shown.
// Reset clears every valid bit and loads mode 0 and weight 154.
// When the receiver stalls the whole pipeline holds; in_ready_o drops only
// while a result waits in the output register and out_ready_i is low.
module pixel_blend_mode_unit_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bmu_pkg::pix_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bmu_pkg::pix_out_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bmu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int LAT = bmu_pkg::LATENCY;

  logic [3:0] mode_q;
  logic [8:0] alpha_q;
  logic [LAT-1:0] vld_q;
  logic en;

  logic signed [bmu_pkg::NUM_W-1:0] num [3];
  logic [bmu_pkg::DEN_W-1:0] den [3];
  logic [bmu_pkg::CB-1:0] a_ch [3];
  logic [bmu_pkg::CB-1:0] b_ch [3];
  logic [bmu_pkg::CB-1:0] q_ch [3];

  // advance whenever the output register is empty or being taken
  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 4'(bmu_pkg::MODE_TRANSP);
      alpha_q <= bmu_pkg::ALPHA_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bmu_pkg::CFG_MODE:  mode_q  <= cfg_data_i[3:0];
        bmu_pkg::CFG_ALPHA: alpha_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // valid bits travel alongside the channel data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign a_ch[0] = in_data_i.a_blue;
  assign a_ch[1] = in_data_i.a_green;
  assign a_ch[2] = in_data_i.a_red;
  assign b_ch[0] = in_data_i.b_blue;
  assign b_ch[1] = in_data_i.b_green;
  assign b_ch[2] = in_data_i.b_red;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    bmu_front u_front (
      .clk_i   (clk_i),
      .en_i    (en),
      .mode_i  (mode_q),
      .alpha_i (alpha_q),
      .a_i     (a_ch[c]),
      .b_i     (b_ch[c]),
      .num_o   (num[c]),
      .den_o   (den[c])
    );

    bmu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[c]),
      .den_i (den[c]),
      .q_o   (q_ch[c])
    );
  end

  assign out_data_o.out_blue  = q_ch[0];
  assign out_data_o.out_green = q_ch[1];
  assign out_data_o.out_red   = q_ch[2];

endmodule

// ===== rtl/bmu_front.sv =====
`timescale 1ns / 1ps

// Two stages: per-mode products, then the soft light product and final
// numerator. Every mode ends as a ratio num/den for the rounding divider.
module bmu_front (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [3:0]                  mode_i,
  input  logic [8:0]                  alpha_i,
  input  logic [bmu_pkg::CB-1:0]      a_i,
  input  logic [bmu_pkg::CB-1:0]      b_i,
  output logic signed [bmu_pkg::NUM_W-1:0] num_o,
  output logic [bmu_pkg::DEN_W-1:0]   den_o
);

  localparam int NW = bmu_pkg::NUM_W;

  logic signed [NW-1:0] base_d, base_q;
  logic [bmu_pkg::DEN_W-1:0] den_d, den_q, den2_q;
  logic signed [bmu_pkg::K_W-1:0] k_d, k_q;
  logic [bmu_pkg::OP_W-1:0] op_d, op_q;
  logic signed [bmu_pkg::K_W+bmu_pkg::OP_W:0] prod;
  logic signed [NW-1:0] num_q;

  logic signed [NW-1:0] a_n, b_n, m_n, al_n, s_n, op_n;
  logic [8:0] al;

  always_comb begin
    a_n  = $signed(NW'(a_i));
    b_n  = $signed(NW'(b_i));
    m_n  = $signed(NW'(bmu_pkg::CODE_MAX));
    al   = alpha_i[8] ? 9'd256 : alpha_i;
    al_n = $signed(NW'(al));
    s_n  = $signed(NW'(bmu_pkg::SQRT_TBL[b_i]));
    op_n = '0;
    k_d  = '0;
    den_d = bmu_pkg::DEN_W'(1);
    base_d = a_n;
    case (bmu_pkg::mode_e'(mode_i))
      bmu_pkg::MODE_TRANSP: begin
        base_d = (NW'(256) - al_n) * a_n + al_n * b_n;
        den_d  = bmu_pkg::DEN_W'(256);
      end
      bmu_pkg::MODE_DARKEN:  base_d = (a_n < b_n) ? a_n : b_n;
      bmu_pkg::MODE_LIGHTEN: base_d = (a_n > b_n) ? a_n : b_n;
      bmu_pkg::MODE_MULTIPLY: begin
        base_d = a_n * b_n;
        den_d  = bmu_pkg::DEN_W'(bmu_pkg::CODE_MAX);
      end
      bmu_pkg::MODE_SCREEN: begin
        base_d = m_n * m_n - (m_n - a_n) * (m_n - b_n);
        den_d  = bmu_pkg::DEN_W'(bmu_pkg::CODE_MAX);
      end
      bmu_pkg::MODE_ADD:     base_d = a_n + b_n;
      bmu_pkg::MODE_LINBURN: base_d = a_n + b_n - m_n;
      bmu_pkg::MODE_DODGE: begin
        if (a_n == m_n) begin
          base_d = m_n;
        end else begin
          base_d = m_n * b_n;
          den_d  = bmu_pkg::DEN_W'(m_n - a_n);
        end
      end
      bmu_pkg::MODE_BURN: begin
        if (a_n == '0) begin
          base_d = '0;
        end else begin
          base_d = m_n * (a_n + b_n - m_n);
          den_d  = bmu_pkg::DEN_W'(a_n);
        end
      end
      bmu_pkg::MODE_OVERLAY: begin
        den_d = bmu_pkg::DEN_W'(bmu_pkg::CODE_MAX);
        if ((b_n <<< 1) <= m_n) begin
          base_d = (a_n * b_n) <<< 1;
        end else begin
          base_d = m_n * m_n - (((m_n - a_n) * (m_n - b_n)) <<< 1);
        end
      end
      bmu_pkg::MODE_HARDLIGHT: begin
        den_d = bmu_pkg::DEN_W'(bmu_pkg::CODE_MAX);
        if ((a_n <<< 1) <= m_n) begin
          base_d = (a_n * b_n) <<< 1;
        end else begin
          base_d = m_n * m_n - (((m_n - a_n) * (m_n - b_n)) <<< 1);
        end
      end
      bmu_pkg::MODE_SOFTLIGHT: begin
        k_d = bmu_pkg::K_W'((a_n <<< 1) - m_n);
        if ((a_n <<< 1) <= m_n) begin
          op_n   = b_n * (m_n - b_n);
          base_d = b_n * m_n * m_n;
          den_d  = bmu_pkg::DEN_W'(m_n * m_n);
        end else begin
          op_n   = m_n * s_n - (b_n <<< 16);
          base_d = (b_n * m_n) <<< 16;
          den_d  = bmu_pkg::DEN_W'(m_n <<< 16);
        end
      end
      bmu_pkg::MODE_DIFF: base_d = (a_n > b_n) ? a_n - b_n : b_n - a_n;
      default: base_d = a_n;
    endcase
    op_d = bmu_pkg::OP_W'(op_n);
  end

  assign prod = $signed(k_q) * $signed({1'b0, op_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= base_d;
      den_q  <= den_d;
      k_q    <= k_d;
      op_q   <= op_d;
      num_q  <= base_q + NW'(prod);
      den2_q <= den_q;
    end
  end

  assign num_o = num_q;
  assign den_o = den2_q;

endmodule

// ===== rtl/bmu_div.sv =====
`timescale 1ns / 1ps

// Rounding divider: round(num/den), ties up, clamped to 0..max.
// One set-up stage, then two restoring quotient bits per stage.
module bmu_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [bmu_pkg::NUM_W-1:0] num_i,
  input  logic [bmu_pkg::DEN_W-1:0]        den_i,
  output logic [bmu_pkg::CB-1:0]           q_o
);

  localparam int RW = bmu_pkg::NUM_W + 1;
  localparam int DW = bmu_pkg::DEN_W + 1;
  localparam int NS = bmu_pkg::DIV_STAGES;

  logic [RW-1:0] r_q [NS+1];
  logic [DW-1:0] d_q [NS+1];
  logic [bmu_pkg::CB-1:0] q_q [NS+1];

  logic [RW-1:0] n_full;
  logic [DW-1:0] d_full;
  logic [RW-1:0] r_d0;
  logic [bmu_pkg::CB-1:0] q_d0;

  always_comb begin
    n_full = {num_i, 1'b0} + RW'(den_i);
    d_full = {den_i, 1'b0};
    r_d0   = n_full;
    q_d0   = '0;
    if (num_i[bmu_pkg::NUM_W-1] || num_i == '0) begin
      r_d0 = '0;
    end else if (n_full >= (RW'(d_full) << bmu_pkg::CB)) begin
      // saturate: quotient beyond full scale
      r_d0 = '0;
      q_d0 = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= r_d0;
      d_q[0] <= d_full;
      q_q[0] <= q_d0;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [RW-1:0] r_d;
    logic [bmu_pkg::CB-1:0] q_d;
    logic [RW-1:0] dsh;

    always_comb begin
      r_d = r_q[s];
      q_d = q_q[s];
      dsh = '0;
      for (int j = 0; j < 2; j++) begin
        if (bmu_pkg::CB - 1 - 2 * s - j >= 0) begin
          dsh = RW'(d_q[s]) << (bmu_pkg::CB - 1 - 2 * s - j);
          if (r_d >= dsh) begin
            r_d = r_d - dsh;
            q_d[bmu_pkg::CB - 1 - 2 * s - j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s+1] <= r_d;
        d_q[s+1] <= d_q[s];
        q_q[s+1] <= q_d;
      end
    end
  end

  assign q_o = q_q[NS];

endmodule
